// ----- hw/rtl/pesrm_pkg.sv -----
// Shared types and constants for the equal-step run merger.
// No dependencies; every other file of the block imports this package.

package pesrm_pkg;

  localparam int COORD_BITS   = 16;
  localparam int STEP_BITS    = COORD_BITS + 1;
  localparam int REMOVED_BITS = 16;
  localparam int RES_MAX      = 3;
  localparam int RES_CNT_BITS = 2;

  localparam logic [REMOVED_BITS-1:0] REMOVED_SAT = '1;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_ONE   = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         move;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         move;
    logic                         list_end;
    logic                         item_done;
    logic [REMOVED_BITS-1:0]      removed;
  } res_t;

  typedef res_t [RES_MAX-1:0] res_list_t;

endpackage

// ----- hw/rtl/pesrm_in_if.sv -----
// Input point channel: valid/ready handshake with the point payload.
// Depends on pesrm_pkg.

interface pesrm_in_if import pesrm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic                         in_move;
  logic                         in_last;

  modport source (output valid, output in_x, output in_y, output in_move, output in_last,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_move, input in_last,
                  output ready);
endinterface

// ----- hw/rtl/pesrm_out_if.sv -----
// Result channel: valid/ready handshake carrying one kept point per transfer.
// Depends on pesrm_pkg.

interface pesrm_out_if import pesrm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_move;
  logic                         out_list_end;
  logic                         out_item_done;
  logic [REMOVED_BITS-1:0]      out_removed;

  modport source (output valid, output out_x, output out_y, output out_move,
                  output out_list_end, output out_item_done, output out_removed,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_move,
                  input out_list_end, input out_item_done, input out_removed,
                  output ready);
endinterface

// ----- hw/rtl/pesrm_core.sv -----
// Run state and per-point merge decision: holds start/prev/step/count state
// and builds the list of kept points caused by one point. Depends on pesrm_pkg.

module pesrm_core import pesrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  item_t                   item,
  output res_list_t               res,
  output logic [RES_CNT_BITS-1:0] res_n
);

  phase_t                       phase_r, phase_nxt;
  logic signed [COORD_BITS-1:0] start_x_r, start_y_r, start_x_nxt, start_y_nxt;
  logic                         start_move_r, start_move_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                         prev_move_r;
  logic                         pis_r, pis_nxt;
  logic signed [STEP_BITS-1:0]  ref_dx_r, ref_dy_r, ref_dx_nxt, ref_dy_nxt;
  logic [REMOVED_BITS-1:0]      removed_r, removed_nxt;

  logic signed [STEP_BITS-1:0]  dx, dy;
  logic                         brk;

  assign dx = $signed({item.x[COORD_BITS-1], item.x}) -
              $signed({prev_x_r[COORD_BITS-1], prev_x_r});
  assign dy = $signed({item.y[COORD_BITS-1], item.y}) -
              $signed({prev_y_r[COORD_BITS-1], prev_y_r});

  always_comb begin
    case (phase_r)
      PH_FIRST: brk = 1'b0;
      PH_ONE:   brk = item.move;
      default:  brk = (dx != ref_dx_r) || (dy != ref_dy_r) || item.move;
    endcase
  end

  // next state
  always_comb begin
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    start_move_nxt = start_move_r;
    pis_nxt        = pis_r;
    ref_dx_nxt     = ref_dx_r;
    ref_dy_nxt     = ref_dy_r;
    removed_nxt    = removed_r;
    phase_nxt      = PH_RUN;
    if (phase_r == PH_FIRST) begin
      start_x_nxt    = item.x;
      start_y_nxt    = item.y;
      start_move_nxt = item.move;
      pis_nxt        = 1'b1;
      ref_dx_nxt     = '0;
      ref_dy_nxt     = '0;
      removed_nxt    = '0;
      phase_nxt      = PH_ONE;
    end else begin
      if (brk || phase_r == PH_ONE) begin
        ref_dx_nxt = dx;
        ref_dy_nxt = dy;
      end
      if (brk) begin
        start_x_nxt    = item.x;
        start_y_nxt    = item.y;
        start_move_nxt = item.move;
        pis_nxt        = 1'b1;
      end else begin
        if (!pis_r && removed_r != REMOVED_SAT)
          removed_nxt = removed_r + 1'b1;
        pis_nxt = 1'b0;
      end
    end
    if (item.last)
      phase_nxt = PH_FIRST;
  end

  // result list: old start, old prev on a break; then one or two end-of-list points
  always_comb begin
    res_t                    cand [4];
    logic [3:0]              cv;
    logic [RES_CNT_BITS-1:0] n;
    cand[0] = '{x: start_x_r, y: start_y_r, move: start_move_r,
                list_end: 1'b0, item_done: 1'b0, removed: '0};
    cand[1] = '{x: prev_x_r, y: prev_y_r, move: prev_move_r,
                list_end: 1'b0, item_done: 1'b0, removed: '0};
    cand[2] = '{x: start_x_nxt, y: start_y_nxt, move: start_move_nxt,
                list_end: pis_nxt, item_done: 1'b0,
                removed: pis_nxt ? removed_nxt : '0};
    cand[3] = '{x: item.x, y: item.y, move: item.move,
                list_end: 1'b1, item_done: 1'b0, removed: removed_nxt};
    cv[0] = brk;
    cv[1] = brk && !pis_r;
    cv[2] = item.last;
    cv[3] = item.last && !pis_nxt;
    cand[0].item_done = cv[0] && !(cv[1] || cv[2] || cv[3]);
    cand[1].item_done = cv[1] && !(cv[2] || cv[3]);
    cand[2].item_done = cv[2] && !cv[3];
    cand[3].item_done = cv[3];
    res = '0;
    n   = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        res[n[RES_CNT_BITS-1:0]] = cand[i];
        n = n + 1'b1;
      end
    end
    res_n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      pis_r     <= 1'b1;
      removed_r <= '0;
      ref_dx_r  <= '0;
      ref_dy_r  <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      pis_r     <= pis_nxt;
      removed_r <= removed_nxt;
      ref_dx_r  <= ref_dx_nxt;
      ref_dy_r  <= ref_dy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      start_move_r <= start_move_nxt;
      prev_x_r     <= item.x;
      prev_y_r     <= item.y;
      prev_move_r  <= item.move;
    end
  end

endmodule

// ----- hw/rtl/polyline_equal_step_run_merge.sv -----
// Equal-step run merger top level. Depends on pesrm_pkg, pesrm_in_if,
// pesrm_out_if and pesrm_core.
//
// Points are registered on input, the merge decision is taken combinationally
// and up to three kept points are loaded into a small result list that drains
// one transfer per cycle while the output is ready. A point that causes no
// result leaves the list free, so one point can be taken every cycle while no
// results are pending; a point that causes results holds the next one until its
// last result is taken. Each point passes the input and result list registers.

module polyline_equal_step_run_merge import pesrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pesrm_in_if.sink    in_chan,
  pesrm_out_if.source out_chan
);

  logic                    stg_valid_r;
  item_t                   stg_item_r;
  res_list_t               pend_r, pend_nxt;
  logic [RES_CNT_BITS-1:0] pend_cnt_r, pend_cnt_nxt;

  res_list_t               res;
  logic [RES_CNT_BITS-1:0] res_n;
  logic                    pend_free, load, pop, in_xfer;

  assign pop       = (pend_cnt_r != '0) && out_chan.ready;
  assign pend_free = (pend_cnt_r == '0) ||
                     (pend_cnt_r == RES_CNT_BITS'(1) && out_chan.ready);
  assign load      = stg_valid_r && pend_free;
  assign in_chan.ready = !stg_valid_r || load;
  assign in_xfer   = in_chan.valid && in_chan.ready;

  pesrm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (load),
    .item    (stg_item_r),
    .res     (res),
    .res_n   (res_n)
  );

  always_comb begin
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    if (load) begin
      pend_nxt     = res;
      pend_cnt_nxt = res_n;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++)
        pend_nxt[i] = pend_r[i+1];
      pend_cnt_nxt = pend_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      pend_cnt_r  <= '0;
    end else begin
      if (in_xfer)
        stg_valid_r <= 1'b1;
      else if (load)
        stg_valid_r <= 1'b0;
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer)
      stg_item_r <= '{x: in_chan.in_x, y: in_chan.in_y,
                      move: in_chan.in_move, last: in_chan.in_last};
    pend_r <= pend_nxt;
  end

  assign out_chan.valid         = (pend_cnt_r != '0);
  assign out_chan.out_x         = pend_r[0].x;
  assign out_chan.out_y         = pend_r[0].y;
  assign out_chan.out_move      = pend_r[0].move;
  assign out_chan.out_list_end  = pend_r[0].list_end;
  assign out_chan.out_item_done = pend_r[0].item_done;
  assign out_chan.out_removed   = pend_r[0].removed;

  // list never overfills, and done marks only the final entry of a list
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= RES_CNT_BITS'(RES_MAX))
    else $error("result list count out of range");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_item_done) |-> pend_cnt_r == RES_CNT_BITS'(1))
    else $error("item done flagged before final result of the point");

  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_list_end) |-> out_chan.out_item_done)
    else $error("list end not on final result");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.out_list_end) |-> out_chan.out_removed == '0)
    else $error("removed count shown away from list end");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> pend_cnt_r == $past(pend_cnt_r) - 1'b1)
    else $error("result list lost or repeated an entry");

endmodule

// ----- tb/sv/polyline_equal_step_run_merge_tb.sv -----
// Self-checking bench for the equal-step run merger: a point driver, a result
// sink with its own stall pattern, and a monitor that predicts kept points.
// Depends on pesrm_pkg, pesrm_in_if, pesrm_out_if and the block itself.

module polyline_equal_step_run_merge_tb import pesrm_pkg::*; ();

  localparam int RESET_CYCLES = 9;
  localparam int RAND_ITEMS   = 360;
  localparam int LONG_POINTS  = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 2_500_000;

  typedef enum int {PACE_FREE, PACE_PATTERN, PACE_SPARSE} pace_t;

  typedef struct {
    item_t pt;
    bit    hold;
  } queued_pt_t;

  logic clk = 1'b0;
  logic rst_n;

  pesrm_in_if  in_chan ();
  pesrm_out_if out_chan ();

  polyline_equal_step_run_merge u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  queued_pt_t pts_q[$];
  res_t       kept_q[$];
  int         n_total   = 0;
  int         n_taken   = 0;
  int         n_errors  = 0;
  int         n_results = 0;
  int         n_cycles  = 0;
  logic       settled;

  // merger state as the bench sees it
  phase_t                       ph = PH_FIRST;
  logic signed [COORD_BITS-1:0] run_x = '0, run_y = '0, last_x = '0, last_y = '0;
  logic                         run_mv = 1'b0, last_mv = 1'b0, last_is_start = 1'b1;
  logic [STEP_BITS-1:0]         step_dx = '0, step_dy = '0;
  logic [REMOVED_BITS-1:0]      dropped = '0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0d: %s", n_cycles, msg);
    n_errors++;
  endtask

  function automatic void keep(input logic signed [COORD_BITS-1:0] x, y,
                               input logic mv, fin);
    res_t r;
    r.x         = x;
    r.y         = y;
    r.move      = mv;
    r.list_end  = fin;
    r.item_done = 1'b0;
    r.removed   = fin ? dropped : '0;
    kept_q.push_back(r);
  endfunction

  task automatic merge_point(input item_t pt);
    logic [STEP_BITS-1:0] dx, dy;
    logic                 brk;
    int                   n;
    n = 0;
    if (ph == PH_FIRST) begin
      run_x = pt.x; run_y = pt.y; run_mv = pt.move;
      last_x = pt.x; last_y = pt.y; last_mv = pt.move;
      last_is_start = 1'b1;
      step_dx = '0;
      step_dy = '0;
      dropped = '0;
      ph = PH_ONE;
    end else begin
      dx = {pt.x[COORD_BITS-1], pt.x} - {last_x[COORD_BITS-1], last_x};
      dy = {pt.y[COORD_BITS-1], pt.y} - {last_y[COORD_BITS-1], last_y};
      if (ph == PH_ONE) begin
        // second point fixes the step; only a move can break here
        step_dx = dx;
        step_dy = dy;
        brk = pt.move;
        ph = PH_RUN;
      end else begin
        brk = (dx != step_dx) || (dy != step_dy) || pt.move;
      end
      if (brk) begin
        keep(run_x, run_y, run_mv, 1'b0);
        n++;
        if (!last_is_start) begin
          keep(last_x, last_y, last_mv, 1'b0);
          n++;
        end
        run_x = pt.x; run_y = pt.y; run_mv = pt.move;
        step_dx = dx;
        step_dy = dy;
        last_is_start = 1'b1;
      end else begin
        if (!last_is_start && dropped != REMOVED_SAT) dropped = dropped + 1'b1;
        last_is_start = 1'b0;
      end
      last_x = pt.x; last_y = pt.y; last_mv = pt.move;
    end
    if (pt.last) begin
      if (last_is_start) begin
        keep(run_x, run_y, run_mv, 1'b1);
        n++;
      end else begin
        keep(run_x, run_y, run_mv, 1'b0);
        keep(last_x, last_y, last_mv, 1'b1);
        n += 2;
      end
      ph = PH_FIRST;
    end
    if (n > 0) kept_q[kept_q.size()-1].item_done = 1'b1;
  endtask

  task automatic add_point(input logic [COORD_BITS-1:0] x, y, input logic mv, lst,
                           input bit hold);
    queued_pt_t q;
    q.pt.x    = x;
    q.pt.y    = y;
    q.pt.move = mv;
    q.pt.last = lst;
    q.hold    = hold;
    pts_q.push_back(q);
    n_total++;
  endtask

  task automatic add_random_lists(input int target);
    int                    made, len, run_left, k;
    bit                    noisy;
    logic [COORD_BITS-1:0] cx, cy, sdx, sdy;
    logic                  mv;
    made = 0;
    sdx = '0;
    sdy = '0;
    while (made < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      noisy = ($urandom_range(0, 6) == 0);
      cx = COORD_BITS'($urandom);
      cy = COORD_BITS'($urandom);
      run_left = 0;
      for (k = 0; k < len; k++) begin
        if (noisy) begin
          cx = COORD_BITS'($urandom);
          cy = COORD_BITS'($urandom);
          mv = 1'($urandom_range(0, 1));
        end else if (run_left == 0) begin
          run_left = $urandom_range(1, 6);
          if ($urandom_range(0, 7) == 0) begin
            sdx = COORD_BITS'($urandom);
            sdy = COORD_BITS'($urandom);
          end else begin
            sdx = 16'($urandom_range(0, 8)) - 16'd4;
            sdy = 16'($urandom_range(0, 8)) - 16'd4;
          end
          mv = ($urandom_range(0, 3) == 0);
          if (mv) begin
            cx = COORD_BITS'($urandom);
            cy = COORD_BITS'($urandom);
          end else begin
            cx = cx + sdx;
            cy = cy + sdy;
          end
        end else begin
          mv = ($urandom_range(0, 30) == 0);
          cx = cx + sdx;
          cy = cy + sdy;
        end
        if (!noisy) run_left--;
        add_point(cx, cy, mv, k == len - 1,
                  (made == 0 && k == 0) || (k == 0 && $urandom_range(0, 60) == 0));
      end
      made += len;
    end
  endtask

  // point driver
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : point_drv
    queued_pt_t nxt;
    if (!rst_n) begin
      in_chan.valid   <= 1'b0;
      in_chan.in_x    <= '0;
      in_chan.in_y    <= '0;
      in_chan.in_move <= 1'b0;
      in_chan.in_last <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (pts_q.size() != 0 && (!pts_q[0].hold || (!in_chan.valid && settled))) begin
        nxt = pts_q.pop_front();
        in_chan.valid   <= 1'b1;
        in_chan.in_x    <= nxt.pt.x;
        in_chan.in_y    <= nxt.pt.y;
        in_chan.in_move <= nxt.pt.move;
        in_chan.in_last <= nxt.pt.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result sink pacing
  pace_t       pace_mode;
  int          pace_left;
  logic [31:0] stall_bits;

  always @(posedge clk) begin : result_pace
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      pace_mode  = PACE_FREE;
      pace_left  = 0;
      stall_bits = '0;
    end else begin
      if (pace_left == 0) begin
        pace_mode  = pace_t'($urandom_range(0, 2));
        pace_left  = $urandom_range(16, 96);
        stall_bits = $urandom;
      end else begin
        pace_left--;
      end
      stall_bits = {stall_bits[0], stall_bits[31:1]};
      case (pace_mode)
        PACE_FREE:    out_chan.ready <= 1'b1;
        PACE_PATTERN: out_chan.ready <= !stall_bits[0];
        default:      out_chan.ready <= stall_bits[0] & stall_bits[3];
      endcase
    end
  end

  // checks kept points first, then predicts from the point taken at this edge
  always @(posedge clk) begin : merge_mon
    res_t   got, want;
    item_t  pt;
    if (!rst_n) begin
      settled <= 1'b1;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.x         = out_chan.out_x;
        got.y         = out_chan.out_y;
        got.move      = out_chan.out_move;
        got.list_end  = out_chan.out_list_end;
        got.item_done = out_chan.out_item_done;
        got.removed   = out_chan.out_removed;
        if (kept_q.size() == 0) begin
          flag_error($sformatf("kept point %0d (%0d,%0d) with nothing pending",
                               n_results, got.x, got.y));
        end else begin
          want = kept_q.pop_front();
          if (got.x !== want.x)
            flag_error($sformatf("kept point %0d: x %0d, want %0d", n_results, got.x, want.x));
          if (got.y !== want.y)
            flag_error($sformatf("kept point %0d: y %0d, want %0d", n_results, got.y, want.y));
          if (got.move !== want.move)
            flag_error($sformatf("kept point %0d: move %b, want %b", n_results,
                                 got.move, want.move));
          if (got.list_end !== want.list_end)
            flag_error($sformatf("kept point %0d: list_end %b, want %b", n_results,
                                 got.list_end, want.list_end));
          if (got.item_done !== want.item_done)
            flag_error($sformatf("kept point %0d: item_done %b, want %b", n_results,
                                 got.item_done, want.item_done));
          if (got.removed !== want.removed)
            flag_error($sformatf("kept point %0d: removed %0d, want %0d", n_results,
                                 got.removed, want.removed));
        end
        n_results++;
      end
      if (in_chan.valid && in_chan.ready) begin
        pt.x    = in_chan.in_x;
        pt.y    = in_chan.in_y;
        pt.move = in_chan.in_move;
        pt.last = in_chan.in_last;
        merge_point(pt);
        n_taken++;
      end
      settled <= (kept_q.size() == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("polyline_equal_step_run_merge_tb: FAIL");
      $finish;
    end
  end

  initial begin : stim
    int k;
    rst_n = 1'b0;

    // single point list, extreme corner, move on the first point
    add_point(16'h8000, 16'h7fff, 1'b1, 1'b1, 1'b0);
    // two-point list, both extremes
    add_point(16'h7fff, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_point(16'h8000, 16'h7fff, 1'b0, 1'b1, 1'b0);
    // two-point list ending on a move
    add_point(16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    add_point(16'd5, -16'sd3, 1'b1, 1'b1, 1'b0);
    // move on the second point, then a short run
    add_point(16'd10, 16'd10, 1'b0, 1'b0, 1'b0);
    add_point(16'd11, 16'd11, 1'b1, 1'b0, 1'b0);
    add_point(16'd12, 16'd12, 1'b0, 1'b0, 1'b0);
    add_point(16'd13, 16'd13, 1'b0, 1'b1, 1'b0);
    // quiet steps, a step change, a move break, end right after a break
    add_point(16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    add_point(16'd2, 16'd1, 1'b0, 1'b0, 1'b0);
    add_point(16'd4, 16'd2, 1'b0, 1'b0, 1'b0);
    add_point(16'd6, 16'd3, 1'b0, 1'b0, 1'b0);
    add_point(16'd6, 16'd5, 1'b0, 1'b0, 1'b0);
    add_point(16'd6, 16'd7, 1'b0, 1'b0, 1'b0);
    add_point(16'd100, -16'sd100, 1'b1, 1'b0, 1'b0);
    add_point(16'd101, -16'sd100, 1'b0, 1'b1, 1'b0);
    // full-scale steps in both directions
    add_point(16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_point(16'h7fff, 16'h7fff, 1'b0, 1'b0, 1'b0);
    add_point(16'h8000, 16'h8000, 1'b0, 1'b1, 1'b0);

    add_random_lists(RAND_ITEMS);

    // one long straight list from the negative edge, so the removed count
    // grows well past anything the short lists reach
    for (k = 0; k < LONG_POINTS; k++)
      add_point(16'(k) + 16'h8000, 16'd7, k == 0, k == LONG_POINTS - 1, k == 0);
    // count must clear again on the next list
    add_point(16'd1, 16'd1, 1'b0, 1'b0, 1'b1);
    add_point(16'd2, 16'd2, 1'b0, 1'b0, 1'b0);
    add_point(16'd3, 16'd3, 1'b0, 1'b1, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken != n_total || kept_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && kept_q.size() == 0) begin
      $display("polyline_equal_step_run_merge_tb: PASS");
    end else begin
      $display("polyline_equal_step_run_merge_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pesrm_pkg.sv
hw/rtl/pesrm_in_if.sv
hw/rtl/pesrm_out_if.sv
hw/rtl/pesrm_core.sv
hw/rtl/polyline_equal_step_run_merge.sv
tb/sv/polyline_equal_step_run_merge_tb.sv
